>>> hw/rtl/rz_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the rolling z-score block.
package rz_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int OUT_BITS    = 24;
    localparam int WIN_BITS    = 7;
    localparam logic [WIN_BITS-1:0] WIN_RESET = 7'd20;

    // Accumulator and arithmetic widths, sized for the largest window the register can hold.
    localparam int SUM_BITS  = SAMPLE_BITS + WIN_BITS;
    localparam int SQ_BITS   = 2 * SAMPLE_BITS;
    localparam int QSUM_BITS = SQ_BITS + WIN_BITS - 1;
    localparam int V_BITS    = QSUM_BITS + WIN_BITS;
    localparam int D_BITS    = SUM_BITS + 1;
    localparam int DSQ_BITS  = 2 * (D_BITS - 1);
    localparam int A_BITS    = V_BITS + WIN_BITS;
    localparam int FRAC_SHIFT = 34;
    localparam int B_BITS    = DSQ_BITS + WIN_BITS + FRAC_SHIFT;
    localparam int QUO_BITS  = 51;
    localparam int DV_BITS   = A_BITS + QUO_BITS;
    localparam int ONE_TOP   = 2 * ((QUO_BITS - 1) / 2);
    localparam int ROOT_STEPS = ONE_TOP / 2 + 1;
    localparam int CNT_BITS  = WIN_BITS;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          restart;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] zscore;
        logic                       warm;
        logic                       flat;
        logic                       saturated;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL1,
        OP_MUL2,
        OP_MUL3,
        OP_MUL4,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        logic   take;
        logic   rd;
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic                warm;
        logic                flat;
        logic                out_free;
        logic [WIN_BITS-1:0] win;
    } sts_t;

endpackage

>>> hw/rtl/rolling_zscore_top.sv
`timescale 1ns / 1ps
// Top level of the rolling window z-score block.
//
// Each sample transaction stores a signed Q12.12 value in a circular history and
// returns one result transaction: the z-score of that sample against the last
// window_length samples since the latest restart, in signed Q8.16, rounded to nearest
// with ties away from zero and clamped to 24 bits (saturated flags the clamp). Until a
// full window has arrived the result is zero with warm low; a window with zero
// variance gives zero with flat high. The window length register is written through
// the cfg channel, resets to 20, and takes effect on the next sample; write it only
// while no transaction is in flight. One sample is worked on at a time. A warm,
// non-flat sample is worked through in steps: a walk of window_length entries of the
// history memory through its single read port, a run of registered multiplies, the
// one-bit-a-cycle restoring divider and the one-bit-a-cycle square root unit. A flat
// window skips the divider and the square root; a sample that is not warm skips all
// of these steps. The result register lets the next sample be accepted while a
// finished result waits to be taken.
module rolling_zscore_top #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_valid,
    output logic                        sample_ready,
    input  rz_pkg::in_item_t            sample_data,
    output logic                        result_valid,
    input  logic                        result_ready,
    output rz_pkg::out_item_t           result_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rz_pkg::WIN_BITS-1:0] cfg_data
);
    import rz_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // The window length register can always take a write.
    assign cfg_ready = 1'b1;

    // The controller sequences the history walk and the arithmetic steps.
    rz_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    // The datapath holds the history, the sums and the divide and root units.
    rz_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

>>> hw/rtl/rz_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine for the rolling z-score block.
module rz_ctrl (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         sample_valid,
    output logic         sample_ready,
    input  rz_pkg::sts_t sts,
    output rz_pkg::cmd_t cmd
);
    import rz_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_DRAIN,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_MUL4,
        S_DIV_INIT,
        S_DIV,
        S_SQRT_INIT,
        S_SQRT,
        S_FIN
    } state_t;

    state_t              state_reg;
    logic [CNT_BITS-1:0] cnt_reg;

    assign sample_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd.take = sample_valid && (state_reg == S_IDLE);
        cmd.rd   = (state_reg == S_READ);
        unique case (state_reg)
            S_MUL1:      cmd.op = OP_MUL1;
            S_MUL2:      cmd.op = OP_MUL2;
            S_MUL3:      cmd.op = OP_MUL3;
            S_MUL4:      cmd.op = OP_MUL4;
            S_DIV_INIT:  cmd.op = OP_DIV_INIT;
            S_DIV:       cmd.op = OP_DIV_STEP;
            S_SQRT_INIT: cmd.op = OP_SQRT_INIT;
            S_SQRT:      cmd.op = OP_SQRT_STEP;
            S_FIN:       cmd.op = sts.out_free ? OP_FINISH : OP_NONE;
            default:     cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (sample_valid)
                        state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (sts.warm)
                    begin
                        cnt_reg   <= CNT_BITS'(sts.win - WIN_BITS'(1));
                        state_reg <= S_READ;
                    end
                    else
                        state_reg <= S_FIN;
                end
                S_READ:
                begin
                    if (cnt_reg == '0)
                    begin
                        cnt_reg   <= CNT_BITS'(1);
                        state_reg <= S_DRAIN;
                    end
                    else
                        cnt_reg <= cnt_reg - CNT_BITS'(1);
                end
                S_DRAIN:
                begin
                    if (cnt_reg == '0)
                        state_reg <= S_MUL1;
                    else
                        cnt_reg <= cnt_reg - CNT_BITS'(1);
                end
                S_MUL1: state_reg <= S_MUL2;
                S_MUL2: state_reg <= S_MUL3;
                S_MUL3: state_reg <= S_MUL4;
                S_MUL4:
                begin
                    if (sts.flat)
                        state_reg <= S_FIN;
                    else
                        state_reg <= S_DIV_INIT;
                end
                S_DIV_INIT:
                begin
                    cnt_reg   <= CNT_BITS'(QUO_BITS - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (cnt_reg == '0)
                        state_reg <= S_SQRT_INIT;
                    else
                        cnt_reg <= cnt_reg - CNT_BITS'(1);
                end
                S_SQRT_INIT:
                begin
                    cnt_reg   <= CNT_BITS'(ROOT_STEPS - 1);
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (cnt_reg == '0)
                        state_reg <= S_FIN;
                    else
                        cnt_reg <= cnt_reg - CNT_BITS'(1);
                end
                S_FIN:
                begin
                    if (sts.out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> hw/rtl/rz_dp.sv
`timescale 1ns / 1ps
// Datapath: sample history, window sums, multiplies, divider, square root, result register.
module rz_dp #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [rz_pkg::WIN_BITS-1:0]   cfg_data,
    input  rz_pkg::in_item_t              sample_data,
    output logic                          result_valid,
    input  logic                          result_ready,
    output rz_pkg::out_item_t             result_data,
    input  rz_pkg::cmd_t                  cmd,
    output rz_pkg::sts_t                  sts
);
    import rz_pkg::*;

    localparam int PTR_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FILL_BITS = $clog2(MAX_WINDOW + 1);
    localparam logic [PTR_BITS-1:0]  PTR_LAST = PTR_BITS'(MAX_WINDOW - 1);
    localparam logic [FILL_BITS-1:0] FILL_MAX = FILL_BITS'(MAX_WINDOW);
    localparam logic [QUO_BITS-1:0]  NEG_LIMIT = QUO_BITS'(64'd1 << (OUT_BITS - 1));
    localparam logic [QUO_BITS-1:0]  POS_LIMIT = QUO_BITS'((64'd1 << (OUT_BITS - 1)) - 64'd1);

    logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];

    logic [WIN_BITS-1:0]           win_reg;
    logic [PTR_BITS-1:0]           wp_reg;
    logic [FILL_BITS-1:0]          fill_reg;
    logic [PTR_BITS-1:0]           rp_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] rdata_reg;
    logic signed [SAMPLE_BITS-1:0] hd_reg;
    logic [SQ_BITS-1:0]            sq_reg;
    logic                          rv1_reg;
    logic                          rv2_reg;
    logic signed [SUM_BITS-1:0]    sum_reg;
    logic [QSUM_BITS-1:0]          qsum_reg;
    logic [V_BITS-1:0]             wq_reg;
    logic [V_BITS-1:0]             ss_reg;
    logic signed [D_BITS-1:0]      wx_reg;
    logic [V_BITS-1:0]             v_reg;
    logic signed [D_BITS-1:0]      d_reg;
    logic [A_BITS-1:0]             a_reg;
    logic [DSQ_BITS-1:0]           dsq_reg;
    logic                          neg_reg;
    logic [B_BITS-1:0]             rem_reg;
    logic [DV_BITS-1:0]            dv_reg;
    logic [QUO_BITS-1:0]           quo_reg;
    logic                          ovf_reg;
    logic [QUO_BITS-1:0]           num_reg;
    logic [QUO_BITS-1:0]           root_reg;
    logic [QUO_BITS-1:0]           one_reg;
    logic                          result_valid_reg;
    out_item_t                     result_reg;

    logic [PTR_BITS-1:0]            waddr;
    logic [FILL_BITS-1:0]           fill_base;
    logic                           warm;
    logic signed [2*SAMPLE_BITS-1:0] sq_full;
    logic signed [SUM_BITS-1:0]     sum_neg;
    logic [SUM_BITS-2:0]            smag;
    logic signed [D_BITS-1:0]       d_neg;
    logic [D_BITS-2:0]              dmag;
    logic [V_BITS-1:0]              wq_prod;
    logic [V_BITS-1:0]              ss_prod;
    logic signed [D_BITS-1:0]       wx_prod;
    logic [A_BITS-1:0]              a_prod;
    logic [DSQ_BITS-1:0]            dsq_prod;
    logic [B_BITS-1:0]              b_prod;
    logic [DV_BITS-1:0]             rem_ext;
    logic [QUO_BITS:0]              trial;
    logic [QUO_BITS-1:0]            n_val;
    out_item_t                      result_next;

    assign waddr     = sample_data.restart ? '0 : wp_reg;
    assign fill_base = sample_data.restart ? '0 : fill_reg;
    assign warm      = (win_reg >= WIN_BITS'(2)) && (int'(win_reg) <= int'(fill_reg));

    assign sq_full  = rdata_reg * rdata_reg;
    assign sum_neg  = -sum_reg;
    assign smag     = sum_reg[SUM_BITS-1] ? sum_neg[SUM_BITS-2:0] : sum_reg[SUM_BITS-2:0];
    assign d_neg    = -d_reg;
    assign dmag     = d_reg[D_BITS-1] ? d_neg[D_BITS-2:0] : d_reg[D_BITS-2:0];
    assign wq_prod  = V_BITS'(win_reg) * V_BITS'(qsum_reg);
    assign ss_prod  = V_BITS'(smag) * V_BITS'(smag);
    assign wx_prod  = D_BITS'(signed'({1'b0, win_reg})) * D_BITS'(x_reg);
    assign a_prod   = A_BITS'(win_reg) * A_BITS'(v_reg);
    assign dsq_prod = DSQ_BITS'(dmag) * DSQ_BITS'(dmag);
    assign b_prod   = B_BITS'(win_reg - WIN_BITS'(1)) * B_BITS'(dsq_reg);
    assign rem_ext  = DV_BITS'(rem_reg);
    assign trial    = (QUO_BITS + 1)'(root_reg) + (QUO_BITS + 1)'(one_reg);
    assign n_val    = QUO_BITS'(((QUO_BITS + 1)'(root_reg) + (QUO_BITS + 1)'(1)) >> 1);

    assign sts.warm     = warm;
    assign sts.flat     = (v_reg == '0);
    assign sts.out_free = !result_valid_reg || result_ready;
    assign sts.win      = win_reg;

    always_comb
    begin
        result_next = '0;
        priority if (!warm)
        begin
            result_next = '0;
        end
        else if (v_reg == '0)
        begin
            result_next.warm = 1'b1;
            result_next.flat = 1'b1;
        end
        else if (neg_reg)
        begin
            result_next.warm = 1'b1;
            if (ovf_reg || (n_val > NEG_LIMIT))
            begin
                result_next.zscore    = OUT_BITS'(-(64'sd1 <<< (OUT_BITS - 1)));
                result_next.saturated = 1'b1;
            end
            else
                result_next.zscore = -signed'(n_val[OUT_BITS-1:0]);
        end
        else
        begin
            result_next.warm = 1'b1;
            if (ovf_reg || (n_val > POS_LIMIT))
            begin
                result_next.zscore    = signed'(POS_LIMIT[OUT_BITS-1:0]);
                result_next.saturated = 1'b1;
            end
            else
                result_next.zscore = signed'(n_val[OUT_BITS-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            mem[waddr] <= sample_data.sample;
        rdata_reg <= mem[rp_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg          <= WIN_RESET;
            wp_reg           <= '0;
            fill_reg         <= '0;
            rp_reg           <= '0;
            rv1_reg          <= 1'b0;
            rv2_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                win_reg <= cfg_data;
            rv1_reg <= cmd.rd;
            rv2_reg <= rv1_reg;
            if (cmd.take)
            begin
                wp_reg   <= (waddr == PTR_LAST) ? '0 : waddr + PTR_BITS'(1);
                fill_reg <= (fill_base == FILL_MAX) ? fill_base : fill_base + FILL_BITS'(1);
                rp_reg   <= waddr;
            end
            else if (cmd.rd)
                rp_reg <= (rp_reg == '0) ? PTR_LAST : rp_reg - PTR_BITS'(1);
            if (cmd.op == OP_FINISH)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            x_reg <= sample_data.sample;
        if (rv1_reg)
        begin
            sq_reg <= sq_full;
            hd_reg <= rdata_reg;
        end
        if (cmd.take)
        begin
            sum_reg  <= '0;
            qsum_reg <= '0;
        end
        else if (rv2_reg)
        begin
            sum_reg  <= sum_reg + SUM_BITS'(hd_reg);
            qsum_reg <= qsum_reg + QSUM_BITS'(sq_reg);
        end

        unique case (cmd.op)
            OP_MUL1:
            begin
                wq_reg <= wq_prod;
                ss_reg <= ss_prod;
                wx_reg <= wx_prod;
            end
            OP_MUL2:
            begin
                v_reg <= wq_reg - ss_reg;
                d_reg <= wx_reg - D_BITS'(sum_reg);
            end
            OP_MUL3:
            begin
                a_reg   <= a_prod;
                dsq_reg <= dsq_prod;
                neg_reg <= d_reg[D_BITS-1];
            end
            OP_MUL4:
            begin
                rem_reg <= b_prod << FRAC_SHIFT;
            end
            OP_DIV_INIT:
            begin
                ovf_reg <= rem_ext >= (DV_BITS'(a_reg) << QUO_BITS);
                dv_reg  <= DV_BITS'(a_reg) << (QUO_BITS - 1);
                quo_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                if (rem_ext >= dv_reg)
                begin
                    rem_reg <= rem_reg - dv_reg[B_BITS-1:0];
                    quo_reg <= {quo_reg[QUO_BITS-2:0], 1'b1};
                end
                else
                    quo_reg <= {quo_reg[QUO_BITS-2:0], 1'b0};
                dv_reg <= dv_reg >> 1;
            end
            OP_SQRT_INIT:
            begin
                num_reg  <= quo_reg;
                root_reg <= '0;
                one_reg  <= QUO_BITS'(1) << ONE_TOP;
            end
            OP_SQRT_STEP:
            begin
                if ((QUO_BITS + 1)'(num_reg) >= trial)
                begin
                    num_reg  <= num_reg - trial[QUO_BITS-1:0];
                    root_reg <= (root_reg >> 1) + one_reg;
                end
                else
                    root_reg <= root_reg >> 1;
                one_reg <= one_reg >> 2;
            end
            OP_FINISH:
            begin
                result_reg <= result_next;
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FINISH) |-> (!result_valid_reg || result_ready))
        else $error("result register loaded while a transaction is pending");

    a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> (sum_reg == '0 && qsum_reg == '0))
        else $error("window sums not cleared on a new transaction");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg <= PTR_LAST) && (rp_reg <= PTR_LAST) && (fill_reg <= FILL_MAX))
        else $error("history pointer or fill count out of range");

    a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FINISH && warm && v_reg != '0 && ovf_reg) |=> result_reg.saturated)
        else $error("quotient overflow did not saturate the result");
`endif

endmodule
